>>> hw/rtl/pbsmmt_pkg.sv
package pbsmmt_pkg;

    localparam int FIELD_BITS    = 24;
    localparam int IDX_BITS      = 10;
    localparam int CMD_BITS      = 2;
    localparam int COEFF_BITS    = 17;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;
    localparam int EPOCH_BITS    = 8;

    localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_COEFF  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEFAULT_VALUE = 2'd1;

    // 1.0 in Q1.16
    localparam logic [COEFF_BITS-1:0] ONE_Q16 = 17'h10000;

    // epoch 0 marks an entry that was wiped; live epochs run 1 .. all ones
    localparam logic [EPOCH_BITS-1:0] EPOCH_NONE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef struct packed {
        logic [CMD_BITS-1:0]          cmd;
        logic [IDX_BITS-1:0]          bin_index;
        logic signed [FIELD_BITS-1:0] sample;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] floor_value;
        logic signed [FIELD_BITS-1:0] ceiling_value;
        logic signed [FIELD_BITS-1:0] mid_value;
    } t_out;

endpackage

>>> hw/rtl/per_bin_smoothed_min_max_tracker_core.sv
// Per-bin smoothed floor/ceiling tracker. Takes one command per clock while busy is low;
// each command gives exactly one result on o_result, strobed by o_strobe once it has passed
// stages 1, 2 and 3 and the output register, in command order, with no way to hold it off.
// Throughput is set by the read-modify-write loop of the bin memory: an add blocks the
// very next command to the same bin while the add sits in stage 1 (busy then follows
// i_in.bin_index), anything else goes at one per clock. Clear is done by bumping an epoch
// tag kept with each entry; after reset, and on every 255th clear when the tag wraps, busy
// stays high while the memory is swept, one entry per cycle once stages 1 and 2 have drained.
module per_bin_smoothed_min_max_tracker_core
    import pbsmmt_pkg::*;
#(
    parameter int BINS       = 1024,
    parameter int VALUE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_in                      i_in,
    output logic                     o_strobe,
    output t_out                     o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int VB = VALUE_BITS;
    localparam int AW = $clog2(BINS);
    localparam int MW = EPOCH_BITS + 2 * VB;
    localparam int PW = VB + 19;
    localparam logic signed [48:0] VMAX = (49'sd1 <<< (VB - 1)) - 49'sd1;
    localparam logic signed [48:0] VMIN = -VMAX - 49'sd1;

    typedef enum logic {
        ST_WIPE,
        ST_RUN
    } t_state;

    function automatic logic signed [VB-1:0] clamp_field(input logic signed [FIELD_BITS-1:0] v);
        logic signed [48:0] w;
        w = 49'(v);
        if (w > VMAX) begin
            w = VMAX;
        end else if (w < VMIN) begin
            w = VMIN;
        end
        return VB'(w);
    endfunction

    // configuration
    logic [COEFF_BITS-1:0] r_coeff;
    logic [FIELD_BITS-1:0] r_default;
    logic [COEFF_BITS-1:0] coeff_sat;
    logic signed [VB-1:0]  def_v;

    // sweep / epoch control
    t_state                r_state;
    logic [AW-1:0]         r_wipe_cnt;
    logic [EPOCH_BITS-1:0] r_epoch;

    // bin memory: {epoch, floor, ceiling}
    logic [MW-1:0]         r_mem [BINS];
    logic [MW-1:0]         r_rd_data;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MW-1:0]         mem_wdata;
    logic                  wipe_we;

    // stage 1: memory data back, select old values, form the product
    logic                  r1_valid;
    logic [CMD_BITS-1:0]   r1_cmd;
    logic [IDX_BITS-1:0]   r1_idx;
    logic                  r1_inrange;
    logic                  r1_add;
    logic [EPOCH_BITS-1:0] r1_epoch;
    logic signed [VB-1:0]  r1_sample;

    // stage 2: finish the blend, write back
    logic                  r2_valid;
    logic                  r2_add;
    logic [IDX_BITS-1:0]   r2_idx;
    logic [EPOCH_BITS-1:0] r2_epoch;
    logic signed [VB-1:0]  r2_sample;
    logic signed [VB-1:0]  r2_floor;
    logic signed [VB-1:0]  r2_ceil;
    logic                  r2_below;
    logic                  r2_above;
    logic signed [PW-1:0]  r2_prod;

    // stage 3: last written value, source for forwarding
    logic                  r3_valid;
    logic                  r3_add;
    logic [IDX_BITS-1:0]   r3_idx;
    logic [EPOCH_BITS-1:0] r3_epoch;
    logic signed [VB-1:0]  r3_floor;
    logic signed [VB-1:0]  r3_ceil;

    // output register
    logic                  r_strobe;
    t_out                  r_result;

    logic                  accept;
    logic                  in_range;
    logic                  fwd_hit;
    logic                  mem_hit;
    logic signed [VB-1:0]  old_floor;
    logic signed [VB-1:0]  old_ceil;
    logic                  n_below;
    logic                  n_above;
    logic signed [VB-1:0]  n_base;
    logic signed [VB:0]    n_diff;
    logic signed [PW-1:0]  n_prod;
    logic signed [VB+2:0]  n_blend_w;
    logic signed [VB-1:0]  n_blend;
    logic signed [VB-1:0]  n_floor;
    logic signed [VB-1:0]  n_ceil;
    logic signed [VB:0]    n_sum;
    logic signed [VB-1:0]  n_mid;

    assign o_cfg_ready = 1'b1;
    assign coeff_sat   = (r_coeff > ONE_Q16) ? ONE_Q16 : r_coeff;
    assign def_v       = clamp_field(r_default);

    // a pending add holds off the next command only when it addresses the same bin
    assign busy     = (r_state != ST_RUN) || (r1_valid && r1_add && (r1_idx == i_in.bin_index));
    assign accept   = start && !busy;
    assign in_range = 32'(i_in.bin_index) < BINS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff   <= '0;
            r_default <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SMOOTH_COEFF:  r_coeff   <= i_cfg_data[COEFF_BITS-1:0];
                REG_DEFAULT_VALUE: r_default <= i_cfg_data[FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // memory write port: pipeline write-back first, sweep only on an empty pipeline
    assign wipe_we = (r_state == ST_WIPE) && !r1_valid && !r2_valid;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wipe_cnt;
        mem_wdata = {EPOCH_NONE, {(2 * VB){1'b0}}};
        if (r2_valid && r2_add) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r2_idx);
            mem_wdata = {r2_epoch, n_floor, n_ceil};
        end else if (wipe_we) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[AW'(i_in.bin_index)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WIPE;
            r_wipe_cnt <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else begin
            unique case (r_state)
                ST_WIPE: begin
                    if (wipe_we) begin
                        if (r_wipe_cnt == AW'(BINS - 1)) begin
                            r_wipe_cnt <= '0;
                            r_state    <= ST_RUN;
                        end else begin
                            r_wipe_cnt <= r_wipe_cnt + 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (accept && i_in.cmd == CMD_CLEAR) begin
                        if (r_epoch == EPOCH_LAST) begin
                            r_epoch <= EPOCH_FIRST;
                            r_state <= ST_WIPE;
                        end else begin
                            r_epoch <= r_epoch + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_WIPE;
            endcase
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_cmd     <= i_in.cmd;
        r1_idx     <= i_in.bin_index;
        r1_inrange <= in_range;
        r1_add     <= (i_in.cmd == CMD_ADD) && in_range;
        r1_epoch   <= r_epoch;
        r1_sample  <= clamp_field(i_in.sample);
    end

    // the entry stage 2 wrote at the edge that took this read was missed by it; take it from stage 3
    assign fwd_hit = r3_valid && r3_add && (r3_idx == r1_idx) && (r3_epoch == r1_epoch);
    assign mem_hit = r_rd_data[MW-1 -: EPOCH_BITS] == r1_epoch;

    always_comb begin
        old_floor = def_v;
        old_ceil  = def_v;
        if (r1_inrange && r1_cmd != CMD_CLEAR) begin
            if (fwd_hit) begin
                old_floor = r3_floor;
                old_ceil  = r3_ceil;
            end else if (mem_hit) begin
                old_floor = $signed(r_rd_data[2*VB-1 -: VB]);
                old_ceil  = $signed(r_rd_data[VB-1:0]);
            end
        end
        n_below = r1_sample < old_floor;
        n_above = r1_sample > old_ceil;
        n_base  = n_below ? old_floor : old_ceil;
        // (w*s + c*o) >> 16 == s + ((c*(o - s)) >> 16), with w = 1 - c
        n_diff  = (VB + 1)'(n_base) - (VB + 1)'(r1_sample);
        n_prod  = $signed({1'b0, coeff_sat}) * n_diff;
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_add    <= r1_add;
        r2_idx    <= r1_idx;
        r2_epoch  <= r1_epoch;
        r2_sample <= r1_sample;
        r2_floor  <= old_floor;
        r2_ceil   <= old_ceil;
        r2_below  <= n_below;
        r2_above  <= n_above;
        r2_prod   <= n_prod;
    end

    always_comb begin
        n_blend_w = (VB + 3)'(r2_sample) + (VB + 3)'(r2_prod >>> 16);
        n_blend   = VB'(n_blend_w);
        n_floor   = (r2_add && r2_below) ? n_blend : r2_floor;
        n_ceil    = (r2_add && r2_above) ? n_blend : r2_ceil;
    end

    // stage 3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_add   <= r2_add;
        r3_idx   <= r2_idx;
        r3_epoch <= r2_epoch;
        r3_floor <= n_floor;
        r3_ceil  <= n_ceil;
    end

    assign n_sum = (VB + 1)'(r3_floor) + (VB + 1)'(r3_ceil);
    assign n_mid = n_sum[VB:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r3_valid;
        end
        r_result.floor_value   <= FIELD_BITS'(r3_floor);
        r_result.ceiling_value <= FIELD_BITS'(r3_ceil);
        r_result.mid_value     <= FIELD_BITS'(n_mid);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // every accepted command yields its result strobe after stages 1 to 3 and the output register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("result strobe missing after accepted command");

    // the interlock must keep an add and a dependent command out of stages 2 and 1 together
    a_no_raw_hazard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r1_valid && r2_valid && r2_add && (r2_idx == r1_idx) && (r2_epoch == r1_epoch)))
        else $error("unresolved read-after-write on the same bin");

    // floor never rises above ceiling
    a_floor_le_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($signed(o_result.floor_value) <= $signed(o_result.ceiling_value)))
        else $error("floor above ceiling");

    // epoch 0 is reserved for wiped entries
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != EPOCH_NONE)
        else $error("epoch collided with the wiped marker");

endmodule

>>> verif/tb_per_bin_smoothed_min_max_tracker_core.sv
module tb_per_bin_smoothed_min_max_tracker_core
    import pbsmmt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS        = 1024;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [CMD_BITS-1:0]   CMD_SPARE = 2'd3;
    localparam logic [FIELD_BITS-1:0] VAL_MAX   = 24'h7FFFFF;
    localparam logic [FIELD_BITS-1:0] VAL_MIN   = 24'h800000;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     busy;
    t_in                      i_in        = '0;
    logic                     o_strobe;
    t_out                     o_result;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    // shadow of the bin store and registers
    logic signed [FIELD_BITS-1:0] floor_m [BINS];
    logic signed [FIELD_BITS-1:0] ceil_m  [BINS];
    logic                         live_m  [BINS];
    logic [COEFF_BITS-1:0]        coeff_m = '0;
    logic signed [FIELD_BITS-1:0] dflt_m  = '0;

    t_out levels_due [$];
    int   mismatches = 0;
    int   cycles_run = 0;
    int   burst_left = 20;

    per_bin_smoothed_min_max_tracker_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT) begin
            $display("per_bin_smoothed_min_max_tracker_core: mismatch");
            $finish;
        end
    end

    // (w*s + c*old) >>> 16, w = 1.0 - c, c saturated at 1.0
    function automatic logic signed [FIELD_BITS-1:0] blend_toward(
            logic signed [FIELD_BITS-1:0] smp, logic signed [FIELD_BITS-1:0] old);
        longint c;
        longint w;
        longint acc;
        c = (coeff_m > ONE_Q16) ? longint'(ONE_Q16) : longint'(coeff_m);
        w = longint'(ONE_Q16) - c;
        acc = w * longint'(smp) + c * longint'(old);
        return FIELD_BITS'(acc >>> 16);
    endfunction

    function automatic t_out next_bin_levels(t_in it);
        t_out                         r;
        logic signed [FIELD_BITS-1:0] smp;
        logic signed [FIELD_BITS-1:0] fl;
        logic signed [FIELD_BITS-1:0] cl;
        logic signed [FIELD_BITS:0]   total;
        smp = it.sample;
        fl = dflt_m;
        cl = dflt_m;
        if (it.cmd == CMD_CLEAR) begin
            for (int b = 0; b < BINS; b++) live_m[b] = 1'b0;
        end else begin
            if (live_m[it.bin_index]) begin
                fl = floor_m[it.bin_index];
                cl = ceil_m[it.bin_index];
            end
            if (it.cmd == CMD_ADD) begin
                if (smp < fl) fl = blend_toward(smp, fl);
                if (smp > cl) cl = blend_toward(smp, cl);
                floor_m[it.bin_index] = fl;
                ceil_m[it.bin_index]  = cl;
                live_m[it.bin_index]  = 1'b1;
            end
        end
        total = fl + cl;
        r.floor_value   = fl;
        r.ceiling_value = cl;
        r.mid_value     = total[FIELD_BITS:1];
        return r;
    endfunction

    function automatic t_in bin_cmd(logic [CMD_BITS-1:0] cmd, int unsigned bin,
                                    logic [FIELD_BITS-1:0] smp);
        t_in it;
        it.cmd       = cmd;
        it.bin_index = IDX_BITS'(bin);
        it.sample    = smp;
        return it;
    endfunction

    task automatic flag(string what, logic [FIELD_BITS-1:0] want, logic [FIELD_BITS-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endtask

    // outputs are sampled mid-cycle; the strobe lasts one full cycle
    always @(negedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %p with nothing expected", $time, o_result);
            end else begin
                want = levels_due.pop_front();
                if (o_result.floor_value !== want.floor_value)
                    flag("floor_value", want.floor_value, o_result.floor_value);
                if (o_result.ceiling_value !== want.ceiling_value)
                    flag("ceiling_value", want.ceiling_value, o_result.ceiling_value);
                if (o_result.mid_value !== want.mid_value)
                    flag("mid_value", want.mid_value, o_result.mid_value);
            end
        end
    end

    // called on a rising edge; returns on the edge that took the beat or after a gap
    task automatic send_item(t_in it);
        logic taken;
        start <= 1'b1;
        i_in  <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        levels_due.push_back(next_bin_levels(it));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic drain(int unsigned settle);
        logic idle;
        start <= 1'b0;
        @(posedge i_clk);
        while (levels_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
        idle = 1'b0;
        while (!idle) begin
            @(negedge i_clk);
            idle = !busy;
            @(posedge i_clk);
        end
    endtask

    task automatic cfg_beat(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        logic done;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            done = o_cfg_ready;
            @(posedge i_clk);
        end
        if (idx == REG_SMOOTH_COEFF)
            coeff_m = data[COEFF_BITS-1:0];
        else if (idx == REG_DEFAULT_VALUE)
            dflt_m = data;
    endtask

    task automatic set_regs(logic [CFG_DATA_BITS-1:0] coeff_data,
                            logic [CFG_DATA_BITS-1:0] dflt_data);
        drain(SETTLE);
        cfg_beat(REG_SMOOTH_COEFF, coeff_data);
        cfg_beat(REG_DEFAULT_VALUE, dflt_data);
        i_cfg_valid <= 1'b0;
    endtask

    // reset register values: coefficient zero, default zero
    task automatic test_reset_state();
        send_item(bin_cmd(CMD_READ, 0, '0));
        send_item(bin_cmd(CMD_SPARE, BINS - 1, VAL_MAX));
        send_item(bin_cmd(CMD_ADD, BINS - 1, VAL_MAX));
        send_item(bin_cmd(CMD_ADD, BINS - 1, VAL_MIN));
        send_item(bin_cmd(CMD_ADD, 0, VAL_MIN));
        send_item(bin_cmd(CMD_READ, BINS - 1, '0));
    endtask

    task automatic test_coeff_limits();
        // exactly one: nothing moves
        set_regs(24'h010000, VAL_MAX);
        send_item(bin_cmd(CMD_ADD, 3, VAL_MIN));
        send_item(bin_cmd(CMD_ADD, 0, VAL_MAX));
        // above one, upper data bits set: saturates
        set_regs(24'hFFFFFF, VAL_MIN);
        send_item(bin_cmd(CMD_ADD, 4, VAL_MAX));
        send_item(bin_cmd(CMD_ADD, 4, '0));
        // one half, back-to-back adds to one bin
        set_regs(24'h008000, 24'h000100);
        send_item(bin_cmd(CMD_ADD, 7, 24'hFFFFFF));
        send_item(bin_cmd(CMD_ADD, 7, 24'h400000));
        send_item(bin_cmd(CMD_ADD, 7, VAL_MIN));
        send_item(bin_cmd(CMD_READ, 7, '0));
    endtask

    task automatic test_clear_default();
        send_item(bin_cmd(CMD_CLEAR, 7, 24'h5A5A5A));
        send_item(bin_cmd(CMD_READ, 7, '0));
        send_item(bin_cmd(CMD_ADD, 10'h2AA, 24'h0ABCDE));
        // default changed after the clear: wiped bins follow the new value
        set_regs(24'h008000, 24'hFFEC78);
        send_item(bin_cmd(CMD_READ, 7, '0));
        send_item(bin_cmd(CMD_READ, 10'h2AA, '0));
        send_item(bin_cmd(CMD_ADD, 7, 24'h000010));
        send_item(bin_cmd(CMD_READ, 7, '0));
    endtask

    // enough clears to wrap the entry tags at least once
    task automatic test_clear_epochs();
        int unsigned bins_used [8];
        set_regs(CFG_DATA_BITS'($urandom_range(0, 65536)), CFG_DATA_BITS'($urandom));
        foreach (bins_used[k]) bins_used[k] = $urandom_range(0, BINS - 1);
        for (int r = 0; r < 262; r++) begin
            send_item(bin_cmd(CMD_CLEAR, $urandom_range(0, BINS - 1), FIELD_BITS'($urandom)));
            send_item(bin_cmd(CMD_ADD, bins_used[$urandom_range(0, 7)], FIELD_BITS'($urandom)));
            send_item(bin_cmd(CMD_READ, bins_used[$urandom_range(0, 7)], '0));
        end
    endtask

    task automatic test_random_mix();
        logic [CFG_DATA_BITS-1:0] coeff_data;
        logic [CFG_DATA_BITS-1:0] dflt_data;
        logic [CMD_BITS-1:0]      cmd;
        logic [FIELD_BITS-1:0]    smp;
        int unsigned              hot_base;
        int unsigned              bin;
        int unsigned              roll;
        int                       near;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: coeff_data = '0;
                1: coeff_data = 24'h010000;
                2: coeff_data = 24'hFFFFFF;
                3: coeff_data = CFG_DATA_BITS'($urandom);
                default: coeff_data = CFG_DATA_BITS'($urandom_range(0, 65536));
            endcase
            case (ph % 3)
                0: dflt_data = VAL_MAX;
                1: dflt_data = VAL_MIN;
                default: dflt_data = CFG_DATA_BITS'($urandom);
            endcase
            set_regs(coeff_data, dflt_data);
            hot_base = $urandom_range(0, BINS - 4);
            for (int n = 0; n < 110; n++) begin
                if (n == 55) drain(0);
                roll = $urandom_range(0, 99);
                if (roll < 68)      cmd = CMD_ADD;
                else if (roll < 88) cmd = CMD_READ;
                else if (roll < 93) cmd = CMD_SPARE;
                else                cmd = CMD_CLEAR;
                bin = ($urandom_range(0, 1) == 0) ? hot_base + $urandom_range(0, 3)
                                                  : $urandom_range(0, BINS - 1);
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    smp = ($urandom_range(0, 1) == 0) ? VAL_MAX : VAL_MIN;
                end else if (roll < 30) begin
                    near = int'($urandom_range(0, 2000)) - 1000;
                    smp = dflt_data + FIELD_BITS'(near);
                end else begin
                    smp = FIELD_BITS'($urandom);
                end
                send_item(bin_cmd(cmd, bin, smp));
            end
        end
    endtask

    initial begin
        foreach (live_m[b]) live_m[b] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain(0);
        test_reset_state();
        test_coeff_limits();
        test_clear_default();
        test_clear_epochs();
        test_random_mix();
        drain(SETTLE);
        if (mismatches == 0)
            $display("per_bin_smoothed_min_max_tracker_core: match");
        else
            $display("per_bin_smoothed_min_max_tracker_core: mismatch");
        $finish;
    end

endmodule
